### design/sll_pkg.sv
// Shared types and constants for the sorted linked list engine.
// No dependencies.
`timescale 1ns / 1ps
package sll_pkg;

  localparam int OP_W       = 3;
  localparam int LIST_NUM_W = 3;
  localparam int ITEM_NUM_W = 6;
  localparam int KEY_W      = 32;
  localparam int COUNT_W    = 7;
  localparam int STATUS_W   = 2;

  localparam logic [OP_W-1:0] OP_EMPTY  = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LINKED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNLINKED = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMPTY,
    S_SWEEP,
    S_RDOWN,
    S_CLR,
    S_REM,
    S_KEY,
    S_POS,
    S_NXT,
    S_WFIRST,
    S_WALK,
    S_LINK1,
    S_LINK2,
    S_DONE
  } state_t;

endpackage

### design/sll_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/sorted_linked_list_engine_core.sv
// Sorted linked list engine: circular doubly linked lists with sentinels over an item pool.
// A sorted insert walks the list from its sentinel, with one link-memory read per walk step.
// A new request is taken only when idle, once the previous result has moved to the output register;
// a finished result waits in the output register until it is taken.
// Synchronous active-low reset; sentinel and membership state come back at once.
// Depends on sll_pkg and sll_ram.
`timescale 1ns / 1ps
module sorted_linked_list_engine_core import sll_pkg::*; #(
  parameter int NUM_LISTS  = 8,
  parameter int MAX_ITEMS  = 64,
  parameter int TICK_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [LIST_NUM_W-1:0] in_list_number,
  input  logic [ITEM_NUM_W-1:0] in_item_number,
  input  logic [KEY_W-1:0]      in_item_key,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COUNT_W-1:0]    out_item_count,
  output logic [STATUS_W-1:0]   out_status
);

  localparam int NODES = MAX_ITEMS + NUM_LISTS;
  localparam int NW    = $clog2(NODES);
  localparam int IW    = $clog2(MAX_ITEMS);
  localparam int LIW   = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int SW    = $clog2(MAX_ITEMS + 1);
  localparam int CW    = IW + 1;
  localparam logic [NW-1:0] FIRST_SENT = NW'(MAX_ITEMS);
  localparam logic [TICK_WIDTH-1:0] TAIL_KEY = '1;

  state_t                state_r, state_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [LIW-1:0]        ln_r, ln_nxt;
  logic [IW-1:0]         it_r, it_nxt;
  logic [TICK_WIDTH-1:0] key_r, key_nxt;
  logic [NW-1:0]         pos_r, pos_nxt;
  logic [NW-1:0]         cand_r, cand_nxt;
  logic [CW-1:0]         ctr_r, ctr_nxt;
  logic [NW-1:0]         nrd_a_r, prd_a_r;
  logic [NUM_LISTS-1:0]  next_self_r, next_self_nxt;
  logic [NUM_LISTS-1:0]  prev_self_r, prev_self_nxt;
  logic [MAX_ITEMS-1:0]  vld_r, vld_nxt;
  logic [SW-1:0]         size_r [NUM_LISTS];
  logic [SW-1:0]         size_nxt [NUM_LISTS];
  logic [NW-1:0]         cursor_r [NUM_LISTS];
  logic [NW-1:0]         cursor_nxt [NUM_LISTS];
  logic [COUNT_W-1:0]    res_count_r, res_count_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  logic                  nx_we, pv_we, key_we, own_we;
  logic [NW-1:0]         nx_waddr, nx_wdata, nx_raddr, nx_rdata;
  logic [NW-1:0]         pv_waddr, pv_wdata, pv_raddr, pv_rdata;
  logic [IW-1:0]         key_waddr, key_raddr, own_waddr, own_raddr;
  logic [TICK_WIDTH-1:0] key_rdata;
  logic [LIW-1:0]        own_wdata, own_rdata;

  logic                  in_fire, list_ok, item_ok;
  logic [LIW-1:0]        in_ln;
  logic [IW-1:0]         in_it;
  logic [NW-1:0]         next_adj, prev_adj, it_node, sent;
  logic                  walk_stop;
  logic [SW-1:0]         new_size;
  logic [IW-1:0]         sweep_idx;

  function automatic logic [LIW-1:0] sidx(input logic [NW-1:0] node);
    logic [NW-1:0] d;
    d = node - FIRST_SENT;
    return d[LIW-1:0];
  endfunction

  sll_ram #(.WIDTH(NW), .DEPTH(NODES)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );
  sll_ram #(.WIDTH(NW), .DEPTH(NODES)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(pv_raddr), .rdata(pv_rdata)
  );
  sll_ram #(.WIDTH(TICK_WIDTH), .DEPTH(MAX_ITEMS)) u_key (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_r),
    .raddr(key_raddr), .rdata(key_rdata)
  );
  sll_ram #(.WIDTH(LIW), .DEPTH(MAX_ITEMS)) u_owner (
    .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
    .raddr(own_raddr), .rdata(own_rdata)
  );

  assign in_ready       = (state_r == S_IDLE);
  assign in_fire        = in_valid && in_ready;
  assign list_ok        = 32'(in_list_number) < NUM_LISTS;
  assign item_ok        = 32'(in_item_number) < MAX_ITEMS;
  assign in_ln          = LIW'(in_list_number);
  assign in_it          = IW'(in_item_number);
  assign it_node        = NW'(it_r);
  assign sent           = FIRST_SENT + NW'(ln_r);
  assign sweep_idx      = IW'(ctr_r - CW'(1));
  assign out_valid      = out_valid_r;
  assign out_item_count = out_count_r;
  assign out_status     = out_status_r;

  assign next_adj = (nrd_a_r >= FIRST_SENT && next_self_r[sidx(nrd_a_r)]) ? nrd_a_r : nx_rdata;
  assign prev_adj = (prd_a_r >= FIRST_SENT && prev_self_r[sidx(prd_a_r)]) ? prd_a_r : pv_rdata;
  assign walk_stop = (ctr_r == CW'(MAX_ITEMS)) || (cand_r >= FIRST_SENT) || (key_rdata > key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      next_self_r <= '1;
      prev_self_r <= '1;
      vld_r       <= '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        size_r[i]   <= '0;
        cursor_r[i] <= FIRST_SENT + NW'(i);
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      next_self_r <= next_self_nxt;
      prev_self_r <= prev_self_nxt;
      vld_r       <= vld_nxt;
      size_r      <= size_nxt;
      cursor_r    <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    ln_r         <= ln_nxt;
    it_r         <= it_nxt;
    key_r        <= key_nxt;
    pos_r        <= pos_nxt;
    cand_r       <= cand_nxt;
    ctr_r        <= ctr_nxt;
    nrd_a_r      <= nx_raddr;
    prd_a_r      <= pv_raddr;
    res_count_r  <= res_count_nxt;
    res_status_r <= res_status_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    ln_nxt         = ln_r;
    it_nxt         = it_r;
    key_nxt        = key_r;
    pos_nxt        = pos_r;
    cand_nxt       = cand_r;
    ctr_nxt        = ctr_r;
    next_self_nxt  = next_self_r;
    prev_self_nxt  = prev_self_r;
    vld_nxt        = vld_r;
    size_nxt       = size_r;
    cursor_nxt     = cursor_r;
    res_count_nxt  = res_count_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    nx_we = 1'b0; nx_waddr = it_node; nx_wdata = cand_r; nx_raddr = it_node;
    pv_we = 1'b0; pv_waddr = it_node; pv_wdata = pos_r;  pv_raddr = it_node;
    key_we = 1'b0; key_waddr = it_r; key_raddr = it_r;
    own_we = 1'b0; own_waddr = it_r; own_wdata = ln_r; own_raddr = it_r;
    new_size = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt         = in_operation;
          ln_nxt         = in_ln;
          it_nxt         = in_it;
          key_nxt        = TICK_WIDTH'(in_item_key);
          res_count_nxt  = '0;
          res_status_nxt = ST_DONE;
          state_nxt      = S_DONE;
          case (in_operation) inside
            OP_EMPTY: begin
              if (list_ok) state_nxt = S_EMPTY;
            end
            OP_CLEAR: begin
              if (item_ok && vld_r[in_it]) state_nxt = S_RDOWN;
            end
            OP_APPEND, OP_INSERT: begin
              if (list_ok && item_ok) begin
                if (vld_r[in_it]) begin
                  res_count_nxt  = COUNT_W'(size_r[in_ln]);
                  res_status_nxt = ST_LINKED;
                end else begin
                  state_nxt = S_KEY;
                end
              end
            end
            OP_REMOVE: begin
              if (item_ok) begin
                if (vld_r[in_it]) state_nxt = S_RDOWN;
                else res_status_nxt = ST_UNLINKED;
              end
            end
            default: ;
          endcase
        end
      end
      S_EMPTY: begin
        next_self_nxt[ln_r] = 1'b1;
        prev_self_nxt[ln_r] = 1'b1;
        size_nxt[ln_r]      = '0;
        cursor_nxt[ln_r]    = sent;
        ctr_nxt             = '0;
        state_nxt           = S_SWEEP;
      end
      S_SWEEP: begin
        own_raddr = ctr_r[IW-1:0];
        if (ctr_r != '0 && own_rdata == ln_r) vld_nxt[sweep_idx] = 1'b0;
        if (ctr_r == CW'(MAX_ITEMS)) state_nxt = S_DONE;
        else ctr_nxt = ctr_r + CW'(1);
      end
      S_RDOWN: begin
        state_nxt = (op_r == OP_CLEAR) ? S_CLR : S_REM;
      end
      S_CLR: begin
        res_count_nxt = COUNT_W'(size_r[own_rdata]);
        vld_nxt[it_r] = 1'b0;
        state_nxt     = S_DONE;
      end
      S_REM: begin
        pv_we    = 1'b1;
        pv_waddr = nx_rdata;
        pv_wdata = pv_rdata;
        nx_we    = 1'b1;
        nx_waddr = pv_rdata;
        nx_wdata = nx_rdata;
        if (nx_rdata >= FIRST_SENT) prev_self_nxt[sidx(nx_rdata)] = 1'b0;
        if (pv_rdata >= FIRST_SENT) next_self_nxt[sidx(pv_rdata)] = 1'b0;
        if (cursor_r[own_rdata] == it_node) cursor_nxt[own_rdata] = pv_rdata;
        vld_nxt[it_r] = 1'b0;
        new_size = (size_r[own_rdata] != '0) ? size_r[own_rdata] - SW'(1) : '0;
        size_nxt[own_rdata] = new_size;
        res_count_nxt = COUNT_W'(new_size);
        state_nxt     = S_DONE;
      end
      S_KEY: begin
        key_we = 1'b1;
        if (op_r == OP_APPEND) begin
          pv_raddr  = cursor_r[ln_r];
          state_nxt = S_POS;
        end else if (key_r == TAIL_KEY) begin
          pv_raddr  = sent;
          state_nxt = S_POS;
        end else begin
          nx_raddr  = sent;
          pos_nxt   = sent;
          state_nxt = S_WFIRST;
        end
      end
      S_POS: begin
        pos_nxt   = prev_adj;
        nx_raddr  = prev_adj;
        state_nxt = S_NXT;
      end
      S_NXT: begin
        cand_nxt  = next_adj;
        state_nxt = S_LINK1;
      end
      S_WFIRST: begin
        cand_nxt  = next_adj;
        nx_raddr  = next_adj;
        key_raddr = next_adj[IW-1:0];
        ctr_nxt   = '0;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (walk_stop) begin
          state_nxt = S_LINK1;
        end else begin
          pos_nxt   = cand_r;
          cand_nxt  = next_adj;
          nx_raddr  = next_adj;
          key_raddr = next_adj[IW-1:0];
          ctr_nxt   = ctr_r + CW'(1);
        end
      end
      S_LINK1: begin
        nx_we    = 1'b1;
        nx_waddr = it_node;
        nx_wdata = cand_r;
        pv_we    = 1'b1;
        pv_waddr = cand_r;
        pv_wdata = it_node;
        if (cand_r >= FIRST_SENT) prev_self_nxt[sidx(cand_r)] = 1'b0;
        state_nxt = S_LINK2;
      end
      S_LINK2: begin
        pv_we    = 1'b1;
        pv_waddr = it_node;
        pv_wdata = pos_r;
        nx_we    = 1'b1;
        nx_waddr = pos_r;
        nx_wdata = it_node;
        if (pos_r >= FIRST_SENT) next_self_nxt[sidx(pos_r)] = 1'b0;
        own_we        = 1'b1;
        vld_nxt[it_r] = 1'b1;
        new_size = (size_r[ln_r] < SW'(MAX_ITEMS)) ? size_r[ln_r] + SW'(1) : size_r[ln_r];
        size_nxt[ln_r] = new_size;
        res_count_nxt  = COUNT_W'(new_size);
        res_status_nxt = ST_DONE;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = res_count_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### design/sll_chk.sv
// Port-level checks for the sorted linked list engine, bound to its top level.
// Depends on sll_pkg.
`timescale 1ns / 1ps
module sll_chk import sll_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [OP_W-1:0]       in_operation,
  input logic [LIST_NUM_W-1:0] in_list_number,
  input logic [ITEM_NUM_W-1:0] in_item_number,
  input logic [KEY_W-1:0]      in_item_key,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COUNT_W-1:0]    out_item_count,
  input logic [STATUS_W-1:0]   out_status
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice back to back");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item_count) && $stable(out_status))
    else $error("result dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_LINKED ||
                   out_status == ST_UNLINKED))
    else $error("bad status code");

  a_refused_remove: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNLINKED |-> out_item_count == '0)
    else $error("refused remove with nonzero count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_item_count) <= MAX_ITEMS)
    else $error("count above pool size");

endmodule

bind sorted_linked_list_engine_core sll_chk #(.MAX_ITEMS(MAX_ITEMS)) u_sll_chk (.*);
